// ----- src/wss_pkg.sv -----
// Package for the weighted stake selector.
// Holds port field widths, the request and status codes. No dependencies.
`default_nettype none

package wss_pkg;

	localparam int ID_W   = 16;
	localparam int WT_W   = 20;
	localparam int DRAW_W = 24;
	localparam int SUM_W  = 24;
	localparam int CNT_W  = 5;
	localparam int STAT_W = 3;

	typedef enum logic [1:0] {
		REQ_ADD    = 2'd0,
		REQ_REMOVE = 2'd1,
		REQ_SELECT = 2'd2,
		REQ_QUERY  = 2'd3
	} req_t;

	typedef enum logic [STAT_W-1:0] {
		ST_OK         = 3'd0,
		ST_BAD_WEIGHT = 3'd1,
		ST_DUPLICATE  = 3'd2,
		ST_NOT_FOUND  = 3'd3,
		ST_FULL       = 3'd4,
		ST_EMPTY      = 3'd5
	} status_t;

endpackage

`default_nettype wire

// ----- src/weighted_stake_selector.sv -----
// Weighted stake selector: ordered table of identifiers with positive weights.
// Requests arrive on in_valid/in_ready with req_type, entry_id, weight and
// random_draw; one result per request leaves on out_valid/out_ready with
// status, chosen_id, found_weight, total_weight and entry_count.
// Add appends an entry, remove deletes one and closes the gap, query looks an
// identifier up, and select walks cumulative weights to find the first entry
// whose running sum exceeds the draw.
// A request is taken only while the sequencer is idle. The table sits in one
// RAM with a registered read, and the sequencer walks it one entry per cycle;
// a remove adds a further pass over the entries behind the removed one.
// A finished result waits in the output register; the next request is already
// accepted while it waits, and if the receiver still stalls when that one
// completes, the sequencer holds it until the output register is free.
// Reset empties the table and clears the total; no clearing pass is needed,
// since only entries below the count are ever read.
// Depends on wss_pkg, wss_ram and wss_cmp_unit.
`default_nettype none

module weighted_stake_selector import wss_pkg::*; #(
	parameter int MAX_ENTRIES = 16,
	parameter int ID_BITS     = 16,
	parameter int WEIGHT_BITS = 20
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_ready,
	input  wire logic [1:0]        req_type,
	input  wire logic [ID_W-1:0]   entry_id,
	input  wire logic [WT_W-1:0]   weight,
	input  wire logic [DRAW_W-1:0] random_draw,
	output logic                   out_valid,
	input  wire logic              out_ready,
	output logic [STAT_W-1:0]      status,
	output logic [ID_W-1:0]        chosen_id,
	output logic [WT_W-1:0]        found_weight,
	output logic [SUM_W-1:0]       total_weight,
	output logic [CNT_W-1:0]       entry_count
);

	localparam int IdW  = (ID_BITS < ID_W) ? ID_BITS : ID_W;
	localparam int WtW  = (WEIGHT_BITS < WT_W) ? WEIGHT_BITS : WT_W;
	localparam int CntW = $clog2(MAX_ENTRIES + 1);
	localparam int IdxW = $clog2(MAX_ENTRIES);
	localparam int RunW = WtW + CntW;
	localparam int EntW = IdW + WtW;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_SHIFT,
		S_FINISH
	} state_t;

	state_t              state_q;
	req_t                req_q;
	logic [IdW-1:0]      id_q;
	logic [WtW-1:0]      w_q;
	logic [DRAW_W-1:0]   draw_q;
	logic [CntW-1:0]     count_q;
	logic [SUM_W-1:0]    sum_q;
	logic [CntW-1:0]     iss_q;
	logic                vld_s1;
	logic [CntW-1:0]     idx_s1;
	logic [RunW-1:0]     run_q;
	logic [EntW-1:0]     first_q;
	status_t             status_q;
	logic [ID_W-1:0]     chosen_q;
	logic [WT_W-1:0]     fw_q;
	logic                out_valid_q;
	logic [STAT_W-1:0]   out_status_q;
	logic [ID_W-1:0]     out_chosen_q;
	logic [WT_W-1:0]     out_fw_q;
	logic [SUM_W-1:0]    out_total_q;
	logic [CNT_W-1:0]    out_count_q;

	logic [EntW-1:0]     rd_data;
	logic [IdW-1:0]      rd_id;
	logic [WtW-1:0]      rd_wt;
	logic [IdW-1:0]      first_id;
	logic [WtW-1:0]      first_wt;
	logic                hit;
	logic [RunW-1:0]     run_next;
	logic                issue;
	logic                last;
	logic                full;
	logic                hit_now;
	logic                nohit_end;
	logic [CntW-1:0]     idx_prev;
	logic                ram_we;
	logic [IdxW-1:0]     ram_waddr;
	logic [EntW-1:0]     ram_wdata;

	assign rd_id    = rd_data[EntW-1:WtW];
	assign rd_wt    = rd_data[WtW-1:0];
	assign first_id = first_q[EntW-1:WtW];
	assign first_wt = first_q[WtW-1:0];

	wss_ram #(
		.WIDTH(EntW),
		.DEPTH(MAX_ENTRIES)
	) u_table (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(iss_q[IdxW-1:0]),
		.rdata(rd_data)
	);

	wss_cmp_unit #(
		.ID_BITS (IdW),
		.WT_BITS (WtW),
		.RUN_BITS(RunW)
	) u_cmp (
		.sel_mode(req_q == REQ_SELECT),
		.ent_id  (rd_id),
		.ent_wt  (rd_wt),
		.key_id  (id_q),
		.run     (run_q),
		.draw    (draw_q),
		.hit     (hit),
		.run_next(run_next)
	);

	always_comb begin
		issue     = (iss_q < count_q);
		last      = ((idx_s1 + CntW'(1)) == count_q);
		full      = (count_q == CntW'(MAX_ENTRIES));
		hit_now   = vld_s1 && hit;
		nohit_end = (count_q == '0) || (vld_s1 && !hit && last);
		idx_prev  = idx_s1 - CntW'(1);
		ram_we    = 1'b0;
		ram_waddr = idx_prev[IdxW-1:0];
		ram_wdata = rd_data;
		if (state_q == S_SCAN && !hit_now && nohit_end && req_q == REQ_ADD && !full) begin
			// A new entry goes to the end of the table.
			ram_we    = 1'b1;
			ram_waddr = count_q[IdxW-1:0];
			ram_wdata = {id_q, w_q};
		end else if (state_q == S_SHIFT && vld_s1) begin
			// Each entry behind the removed one moves down by one place.
			ram_we = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			req_q        <= REQ_ADD;
			id_q         <= '0;
			w_q          <= '0;
			draw_q       <= '0;
			count_q      <= '0;
			sum_q        <= '0;
			iss_q        <= '0;
			vld_s1       <= 1'b0;
			idx_s1       <= '0;
			run_q        <= '0;
			first_q      <= '0;
			status_q     <= ST_OK;
			chosen_q     <= '0;
			fw_q         <= '0;
			out_valid_q  <= 1'b0;
			out_status_q <= '0;
			out_chosen_q <= '0;
			out_fw_q     <= '0;
			out_total_q  <= '0;
			out_count_q  <= '0;
		end else begin
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						req_q    <= req_t'(req_type);
						id_q     <= entry_id[IdW-1:0];
						w_q      <= weight[WtW-1:0];
						draw_q   <= random_draw;
						iss_q    <= '0;
						vld_s1   <= 1'b0;
						run_q    <= '0;
						status_q <= ST_OK;
						fw_q     <= '0;
						if (req_t'(req_type) == REQ_QUERY) begin
							chosen_q <= ID_W'(entry_id[IdW-1:0]);
						end else begin
							chosen_q <= '0;
						end
						if (req_t'(req_type) == REQ_ADD && weight[WtW-1:0] == '0) begin
							status_q <= ST_BAD_WEIGHT;
							state_q  <= S_FINISH;
						end else begin
							state_q <= S_SCAN;
						end
					end
				end
				S_SCAN: begin
					if (issue) begin
						iss_q  <= iss_q + CntW'(1);
						vld_s1 <= 1'b1;
						idx_s1 <= iss_q;
					end else begin
						vld_s1 <= 1'b0;
					end
					if (vld_s1) begin
						run_q <= run_next;
						if (idx_s1 == '0) begin
							first_q <= rd_data;
						end
					end
					if (hit_now) begin
						vld_s1  <= 1'b0;
						state_q <= S_FINISH;
						case (req_q)
							REQ_ADD: begin
								status_q <= ST_DUPLICATE;
							end
							REQ_REMOVE: begin
								sum_q <= sum_q - SUM_W'(rd_wt);
								if (last) begin
									count_q <= count_q - CntW'(1);
								end else begin
									iss_q   <= idx_s1 + CntW'(1);
									state_q <= S_SHIFT;
								end
							end
							REQ_SELECT: begin
								chosen_q <= ID_W'(rd_id);
								fw_q     <= WT_W'(rd_wt);
							end
							REQ_QUERY: begin
								fw_q <= WT_W'(rd_wt);
							end
							default: begin
								status_q <= ST_OK;
							end
						endcase
					end else if (nohit_end) begin
						vld_s1  <= 1'b0;
						state_q <= S_FINISH;
						case (req_q)
							REQ_ADD: begin
								if (full) begin
									status_q <= ST_FULL;
								end else begin
									count_q <= count_q + CntW'(1);
									sum_q   <= sum_q + SUM_W'(w_q);
								end
							end
							REQ_SELECT: begin
								if (count_q == '0) begin
									status_q <= ST_EMPTY;
								end else if (idx_s1 == '0) begin
									// A draw at or past the total falls back to the first entry.
									chosen_q <= ID_W'(rd_id);
									fw_q     <= WT_W'(rd_wt);
								end else begin
									chosen_q <= ID_W'(first_id);
									fw_q     <= WT_W'(first_wt);
								end
							end
							default: begin
								status_q <= ST_NOT_FOUND;
							end
						endcase
					end
				end
				S_SHIFT: begin
					if (issue) begin
						iss_q  <= iss_q + CntW'(1);
						vld_s1 <= 1'b1;
						idx_s1 <= iss_q;
					end else begin
						vld_s1 <= 1'b0;
					end
					if (vld_s1 && last) begin
						vld_s1  <= 1'b0;
						count_q <= count_q - CntW'(1);
						state_q <= S_FINISH;
					end
				end
				S_FINISH: begin
					if (!out_valid_q || out_ready) begin
						out_valid_q  <= 1'b1;
						out_status_q <= status_q;
						out_chosen_q <= chosen_q;
						out_fw_q     <= fw_q;
						out_total_q  <= sum_q;
						out_count_q  <= CNT_W'(count_q);
						state_q      <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign in_ready     = (state_q == S_IDLE);
	assign out_valid    = out_valid_q;
	assign status       = out_status_q;
	assign chosen_id    = out_chosen_q;
	assign found_weight = out_fw_q;
	assign total_weight = out_total_q;
	assign entry_count  = out_count_q;

endmodule

`default_nettype wire

// ----- src/wss_ram.sv -----
// Generic single write port, single read port RAM with registered read data.
// No dependencies.
`default_nettype none

module wss_ram #(
	parameter int WIDTH = 36,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

// ----- src/wss_cmp_unit.sv -----
// Shared compare unit: identifier match, or running-sum update and draw compare.
// Depends on wss_pkg.
`default_nettype none

module wss_cmp_unit import wss_pkg::*; #(
	parameter int ID_BITS  = 16,
	parameter int WT_BITS  = 20,
	parameter int RUN_BITS = 25
) (
	input  wire logic                sel_mode,
	input  wire logic [ID_BITS-1:0]  ent_id,
	input  wire logic [WT_BITS-1:0]  ent_wt,
	input  wire logic [ID_BITS-1:0]  key_id,
	input  wire logic [RUN_BITS-1:0] run,
	input  wire logic [DRAW_W-1:0]   draw,
	output logic                     hit,
	output logic      [RUN_BITS-1:0] run_next
);

	localparam int CmpW = (RUN_BITS > DRAW_W) ? RUN_BITS : DRAW_W;

	always_comb begin
		run_next = run + RUN_BITS'(ent_wt);
		if (sel_mode) begin
			hit = (CmpW'(draw) < CmpW'(run_next));
		end else begin
			hit = (ent_id == key_id);
		end
	end

endmodule

`default_nettype wire

// ----- tb/tb.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for weighted_stake_selector: a queued request driver,
// a result monitor with its own model of the stake table, and a stalling receiver.
// Depends on wss_pkg and the weighted_stake_selector RTL.

module tb;
	import wss_pkg::*;

	localparam int SLOTS = 16;

	typedef struct {
		req_t                kind;
		logic [ID_W-1:0]     id;
		logic [WT_W-1:0]     wt;
		logic [DRAW_W-1:0]   draw;
		bit                  drain;
		bit                  calm;
	} stake_req_t;

	typedef struct {
		status_t             status;
		logic [ID_W-1:0]     id;
		logic [WT_W-1:0]     fw;
		logic [SUM_W-1:0]    total;
		logic [CNT_W-1:0]    cnt;
	} stake_result_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               in_valid = 1'b0;
	logic               in_ready;
	logic [1:0]         req_type = REQ_ADD;
	logic [ID_W-1:0]    entry_id = '0;
	logic [WT_W-1:0]    weight = '0;
	logic [DRAW_W-1:0]  random_draw = '0;
	logic               out_valid;
	logic               out_ready = 1'b0;
	logic [STAT_W-1:0]  status;
	logic [ID_W-1:0]    chosen_id;
	logic [WT_W-1:0]    found_weight;
	logic [SUM_W-1:0]   total_weight;
	logic [CNT_W-1:0]   entry_count;

	stake_req_t         stake_requests[$];
	stake_result_t      awaited_results[$];
	stake_req_t         next_req;
	stake_req_t         seen_req;
	stake_result_t      head_result;

	// Model of the table, updated as each request is accepted.
	logic [ID_W-1:0]    held_ids[SLOTS];
	logic [WT_W-1:0]    held_weights[SLOTS];
	int                 held_count = 0;
	logic [31:0]        stake_sum = '0;

	int                 mismatches = 0;
	int                 send_gap = 0;
	int                 stall_left = 0;
	int                 calm_left = 0;
	int                 results_taken = 0;

	weighted_stake_selector #(
		.MAX_ENTRIES(SLOTS),
		.ID_BITS(ID_W),
		.WEIGHT_BITS(WT_W)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.req_type(req_type),
		.entry_id(entry_id),
		.weight(weight),
		.random_draw(random_draw),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.status(status),
		.chosen_id(chosen_id),
		.found_weight(found_weight),
		.total_weight(total_weight),
		.entry_count(entry_count)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	task automatic queue_request(req_t kind, logic [ID_W-1:0] id, logic [WT_W-1:0] wt,
			logic [DRAW_W-1:0] draw, bit drain, bit calm);
		stake_req_t rq;
		rq.kind  = kind;
		rq.id    = id;
		rq.wt    = wt;
		rq.draw  = draw;
		rq.drain = drain;
		rq.calm  = calm;
		stake_requests.push_back(rq);
	endtask

	function automatic stake_result_t apply_stake_request(stake_req_t rq);
		stake_result_t res;
		int slot;
		bit picked;
		logic [31:0] running;
		res.status = ST_OK;
		res.id     = '0;
		res.fw     = '0;
		slot = held_count;
		for (int i = held_count - 1; i >= 0; i--)
			if (held_ids[i] == rq.id)
				slot = i;
		case (rq.kind)
			REQ_ADD: begin
				// Zero weight is checked first, then a duplicate, then a full table.
				if (rq.wt == '0)
					res.status = ST_BAD_WEIGHT;
				else if (slot < held_count)
					res.status = ST_DUPLICATE;
				else if (held_count == SLOTS)
					res.status = ST_FULL;
				else begin
					held_ids[held_count]     = rq.id;
					held_weights[held_count] = rq.wt;
					held_count++;
					stake_sum += rq.wt;
				end
			end
			REQ_REMOVE: begin
				if (slot == held_count)
					res.status = ST_NOT_FOUND;
				else begin
					stake_sum -= held_weights[slot];
					for (int i = slot; i < held_count - 1; i++) begin
						held_ids[i]     = held_ids[i + 1];
						held_weights[i] = held_weights[i + 1];
					end
					held_count--;
				end
			end
			REQ_SELECT: begin
				if (held_count == 0)
					res.status = ST_EMPTY;
				else begin
					// A draw at or beyond the total leaves the first entry chosen.
					res.id  = held_ids[0];
					res.fw  = held_weights[0];
					running = '0;
					picked  = 1'b0;
					for (int i = 0; i < held_count; i++) begin
						if (!picked) begin
							running += held_weights[i];
							if ({8'b0, rq.draw} < running) begin
								picked = 1'b1;
								res.id = held_ids[i];
								res.fw = held_weights[i];
							end
						end
					end
				end
			end
			default: begin
				res.id = rq.id;
				if (slot == held_count)
					res.status = ST_NOT_FOUND;
				else
					res.fw = held_weights[slot];
			end
		endcase
		res.total = stake_sum[SUM_W-1:0];
		res.cnt   = CNT_W'(held_count);
		return res;
	endfunction

	function automatic void check_field(string what, logic [31:0] want, logic [31:0] got);
		if (want !== got) begin
			$display("%0t ns: %s expected %0h, got %0h", $time, what, want, got);
			mismatches++;
		end
	endfunction

	// Request driver. An item flagged for draining waits until every result is back.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid    <= 1'b0;
			req_type    <= REQ_ADD;
			entry_id    <= '0;
			weight      <= '0;
			random_draw <= '0;
			send_gap    <= 0;
		end else if (!in_valid || in_ready) begin
			if (send_gap != 0) begin
				in_valid <= 1'b0;
				send_gap <= send_gap - 1;
			end else if (stake_requests.size() != 0 && !(stake_requests[0].drain &&
					(awaited_results.size() != 0 || in_valid))) begin
				next_req = stake_requests.pop_front();
				in_valid    <= 1'b1;
				req_type    <= next_req.kind;
				entry_id    <= next_req.id;
				weight      <= next_req.wt;
				random_draw <= next_req.draw;
				if (!next_req.calm && stake_requests.size() >= 60 && $urandom_range(0, 5) == 0)
					send_gap <= $urandom_range(1, 5);
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Receiver: short random stalls, calm stretches, and one long hold-off that
	// lets the block back up and refuse new requests.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready     <= 1'b0;
			stall_left    <= 0;
			calm_left     <= 0;
			results_taken <= 0;
		end else begin
			if (out_valid && out_ready)
				results_taken <= results_taken + 1;
			if (out_valid && out_ready && results_taken == 99) begin
				out_ready  <= 1'b0;
				stall_left <= 299;
			end else if (stall_left != 0) begin
				out_ready  <= 1'b0;
				stall_left <= stall_left - 1;
			end else if (calm_left != 0) begin
				out_ready <= 1'b1;
				calm_left <= calm_left - 1;
			end else if (stake_requests.size() >= 60 && $urandom_range(0, 7) == 0) begin
				out_ready  <= 1'b0;
				stall_left <= $urandom_range(0, 4);
			end else if (stake_requests.size() >= 60 && $urandom_range(0, 31) == 0) begin
				out_ready <= 1'b1;
				calm_left <= $urandom_range(20, 60);
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	// Monitor: check each result against the oldest prediction, then predict the
	// request accepted on this edge.
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (awaited_results.size() == 0) begin
					$display("%0t ns: result expected none, got status %0h id %0h", $time,
						status, chosen_id);
					mismatches++;
				end else begin
					head_result = awaited_results.pop_front();
					check_field("status", head_result.status, status);
					check_field("chosen_id", head_result.id, chosen_id);
					check_field("found_weight", head_result.fw, found_weight);
					check_field("total_weight", head_result.total, total_weight);
					check_field("entry_count", head_result.cnt, entry_count);
				end
			end
			if (in_valid && in_ready) begin
				seen_req.kind = req_t'(req_type);
				seen_req.id   = entry_id;
				seen_req.wt   = weight;
				seen_req.draw = random_draw;
				awaited_results.push_back(apply_stake_request(seen_req));
			end
		end
	end

	initial begin
		logic [ID_W-1:0] id_pool[24];
		logic [ID_W-1:0] id;
		logic [WT_W-1:0] wt;
		logic [DRAW_W-1:0] draw;
		req_t kind;
		int scale;
		int add_pct;
		int pick;
		bit calm_seg;

		// Directed requests: empty table, rejects, draw edges, full table, removal.
		queue_request(REQ_SELECT, 16'h0000, 20'h00000, 24'h000000, 1'b0, 1'b0);
		queue_request(REQ_REMOVE, 16'h0000, 20'h00000, 24'h000000, 1'b0, 1'b0);
		queue_request(REQ_ADD, 16'hFFFF, 20'h00000, 24'hFFFFFF, 1'b0, 1'b0);
		queue_request(REQ_ADD, 16'h0000, 20'h00001, 24'h000000, 1'b0, 1'b0);
		queue_request(REQ_ADD, 16'hFFFF, 20'hFFFFF, 24'h000000, 1'b0, 1'b0);
		queue_request(REQ_ADD, 16'h0000, 20'h00005, 24'h000000, 1'b0, 1'b0);
		queue_request(REQ_QUERY, 16'hFFFF, 20'h00000, 24'h000000, 1'b0, 1'b0);
		queue_request(REQ_SELECT, 16'h0000, 20'h00000, 24'h0FFFFF, 1'b0, 1'b0);
		queue_request(REQ_SELECT, 16'h0000, 20'h00000, 24'h100000, 1'b0, 1'b0);
		queue_request(REQ_SELECT, 16'h0000, 20'h00000, 24'hFFFFFF, 1'b0, 1'b0);
		for (int i = 1; i <= 14; i++)
			queue_request(REQ_ADD, ID_W'(i), 20'hFFFFF, 24'h000000, 1'b0, 1'b0);
		queue_request(REQ_ADD, 16'h1234, 20'h00003, 24'h000000, 1'b0, 1'b0);
		queue_request(REQ_REMOVE, 16'h0000, 20'h00000, 24'h000000, 1'b0, 1'b0);
		queue_request(REQ_ADD, 16'h8000, 20'hFFFFF, 24'h000000, 1'b0, 1'b0);
		// With all slots at full weight the sum is FFFFF0; one below picks the last.
		queue_request(REQ_SELECT, 16'h0000, 20'h00000, 24'hFFFFEF, 1'b0, 1'b0);
		queue_request(REQ_REMOVE, 16'h0007, 20'h00000, 24'h000000, 1'b0, 1'b0);

		// Random segments over a small pool of identifiers, so that removes and
		// queries hit and the table fills; each segment has its own weight scale.
		id_pool[0] = 16'h0000;
		id_pool[1] = 16'hFFFF;
		for (int i = 2; i < 24; i++)
			id_pool[i] = ID_W'($urandom_range(0, 16'hFFFF));
		for (int seg = 0; seg < 11; seg++) begin
			scale    = $urandom_range(4, 20);
			add_pct  = $urandom_range(20, 50);
			calm_seg = ($urandom_range(0, 3) == 0);
			for (int n = 0; n < 50; n++) begin
				pick = $urandom_range(0, 99);
				if (pick < add_pct)
					kind = REQ_ADD;
				else if (pick < add_pct + 30)
					kind = REQ_REMOVE;
				else if (pick < add_pct + 55)
					kind = REQ_SELECT;
				else
					kind = REQ_QUERY;
				if ($urandom_range(0, 7) == 0)
					id = ID_W'($urandom_range(0, 16'hFFFF));
				else
					id = id_pool[$urandom_range(0, 23)];
				pick = $urandom_range(0, 15);
				if (pick == 0)
					wt = '0;
				else if (pick == 1)
					wt = '1;
				else
					wt = WT_W'($urandom_range(1, (1 << scale) - 1));
				if ($urandom_range(0, 15) == 0)
					draw = DRAW_W'($urandom_range(0, 24'hFFFFFF));
				else
					draw = DRAW_W'($urandom_range(0, (1 << (scale + 3)) - 1));
				queue_request(kind, id, wt, draw, n == 0, calm_seg);
			end
		end

		repeat (9) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;

		while (stake_requests.size() != 0 || in_valid || awaited_results.size() != 0)
			@(negedge clk);
		repeat (40) @(posedge clk);
		if (mismatches == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

	initial begin
		#2000000;
		$display("Mismatches found");
		$finish;
	end

endmodule

// ----- files.f -----
src/wss_pkg.sv
src/wss_ram.sv
src/wss_cmp_unit.sv
src/weighted_stake_selector.sv
tb/tb.sv
